// ===== rtl/bit_field_execute_unit_top_macros.svh =====
// assertion macros of the bit-field execute unit, used by the bfe_flags module
`ifndef BIT_FIELD_EXECUTE_UNIT_TOP_MACROS_SVH
`define BIT_FIELD_EXECUTE_UNIT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfe_pkg.sv =====
// types and constants of the bit-field execute unit
`timescale 1ns / 1ps
package bfe_pkg;

  localparam int unsigned MaxField = 32;
  localparam int unsigned OpW      = 4;
  localparam int unsigned PosW     = 5;
  localparam int unsigned SizeW    = 8;
  localparam int unsigned WinW     = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned IdxW     = $clog2(DataW);
  localparam int unsigned SizeCutW = $clog2(DataW + 1);
  localparam int unsigned FindW    = SizeCutW + 1;

  typedef enum logic [OpW-1:0] {
    OP_EXTZV = 4'd0,
    OP_EXTV  = 4'd1,
    OP_CMPZV = 4'd2,
    OP_CMPV  = 4'd3,
    OP_FFS   = 4'd4,
    OP_FFC   = 4'd5,
    OP_INSV  = 4'd6,
    OP_BBS   = 4'd7,
    OP_BBC   = 4'd8,
    OP_BBSS  = 4'd9,
    OP_BBCS  = 4'd10,
    OP_BBSC  = 4'd11,
    OP_BBCC  = 4'd12
  } op_e;

  // after field alignment
  typedef struct packed {
    op_e                 op;
    logic [PosW-1:0]     pos;
    logic [SizeCutW-1:0] size;
    logic                fault;
    logic [DataW-1:0]    field;
    logic [DataW-1:0]    fmask;
    logic                tbit;
    logic [WinW-1:0]     win;
    logic [DataW-1:0]    opnd;
  } s1_t;

  // after execute
  typedef struct packed {
    op_e              op;
    logic             fault;
    logic             found;
    logic [DataW-1:0] value;
    logic [DataW-1:0] opnd;
    logic [WinW-1:0]  upd;
    logic             wr;
    logic             taken;
  } s2_t;

endpackage

// ===== rtl/bfe_if.sv =====
// handshake interfaces for the input and result channels
`timescale 1ns / 1ps
interface bfe_in_if;
  import bfe_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [PosW-1:0]  position;
  logic [SizeW-1:0] field_size;
  logic [WinW-1:0]  source_window;
  logic [DataW-1:0] operand;

  modport source (
    output valid, op, position, field_size, source_window, operand,
    input  ready
  );
  modport sink (
    input  valid, op, position, field_size, source_window, operand,
    output ready
  );
endinterface

interface bfe_out_if;
  import bfe_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] value_out;
  logic [WinW-1:0]  updated_window;
  logic             window_written;
  logic             flag_n;
  logic             flag_z;
  logic             flag_c;
  logic             flag_v;
  logic             branch_taken;
  logic             reserved_fault;

  modport source (
    output valid, value_out, updated_window, window_written, flag_n, flag_z,
           flag_c, flag_v, branch_taken, reserved_fault,
    input  ready
  );
  modport sink (
    input  valid, value_out, updated_window, window_written, flag_n, flag_z,
           flag_c, flag_v, branch_taken, reserved_fault,
    output ready
  );
endinterface

// ===== rtl/bit_field_execute_unit_top.sv =====
// an accepted input beat passes the align, execute and flag stage registers
// in turn to its result beat; one beat per cycle while out_o.ready holds; each
// stage register has its own valid bit and takes a beat when empty or draining
// a stalled result stays in the flag stage while earlier stages keep filling
// reset clears all stage valid bits; payload registers are not reset
`timescale 1ns / 1ps
module bit_field_execute_unit_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfe_in_if.sink    in_i,
  bfe_out_if.source out_o
);
  import bfe_pkg::*;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2;

  bfe_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .s1_o    (s1)
  );

  bfe_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .s2_o    (s2)
  );

  bfe_flags u_flags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .s2_i    (s2),
    .out_o   (out_o)
  );

endmodule

// ===== rtl/bfe_align.sv =====
// stage 1: field alignment, size mask and reserved operand check
`timescale 1ns / 1ps
module bfe_align (
  input  logic         clk_i,
  input  logic         rst_ni,
  bfe_in_if.sink       in_i,
  output logic         valid_o,
  input  logic         ready_i,
  output bfe_pkg::s1_t s1_o
);
  import bfe_pkg::*;

  logic             valid_q;
  s1_t              s1_q;
  s1_t              s1_d;
  logic [WinW-1:0]  shifted;
  logic [DataW-1:0] fmask;
  logic             is_field_op;

  assign in_i.ready = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign s1_o       = s1_q;

  always_comb begin
    shifted     = in_i.source_window >> in_i.position;
    is_field_op = (in_i.op <= OP_INSV);
    if (in_i.field_size >= SizeW'(DataW)) begin
      fmask = '1;
    end else begin
      fmask = (DataW'(1) << in_i.field_size) - DataW'(1);
    end
    s1_d.op    = op_e'(in_i.op);
    s1_d.pos   = in_i.position;
    s1_d.size  = in_i.field_size[SizeCutW-1:0];
    s1_d.fault = is_field_op && (in_i.field_size > SizeW'(MaxField));
    s1_d.field = shifted[DataW-1:0] & fmask;
    s1_d.fmask = fmask;
    s1_d.tbit  = shifted[0];
    s1_d.win   = in_i.source_window;
    s1_d.opnd  = in_i.operand;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= s1_d;
    end
  end

endmodule

// ===== rtl/bfe_exec.sv =====
// stage 2: sign extension, find first, insert merge and bit test
`timescale 1ns / 1ps
module bfe_exec (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  bfe_pkg::s1_t s1_i,
  output logic         valid_o,
  input  logic         ready_i,
  output bfe_pkg::s2_t s2_o
);
  import bfe_pkg::*;

  logic             valid_q;
  s2_t              s2_q;
  s2_t              s2_d;
  logic             sgn;
  logic [DataW-1:0] ext_val;
  logic [DataW-1:0] fvec;
  logic [IdxW-1:0]  fidx;
  logic             found;
  logic [FindW-1:0] fsum;
  logic [WinW-1:0]  ins_mask;
  logic [WinW-1:0]  ins_data;
  logic [WinW-1:0]  bit_mask;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign s2_o    = s2_q;

  always_comb begin
    // top bit of the field sits where the mask edge is
    sgn = |(s1_i.field & (s1_i.fmask ^ (s1_i.fmask >> 1)));
    if ((s1_i.op == OP_EXTV || s1_i.op == OP_CMPV) && sgn) begin
      ext_val = s1_i.field | ~s1_i.fmask;
    end else begin
      ext_val = s1_i.field;
    end

    fvec  = ((s1_i.op == OP_FFS) ? s1_i.field : ~s1_i.field) & s1_i.fmask;
    found = |fvec;
    fidx  = '0;
    for (int i = DataW - 1; i >= 0; i--) begin
      if (fvec[i]) begin
        fidx = IdxW'(i);
      end
    end
    // not found gives position plus size
    fsum = FindW'(s1_i.pos) + (found ? FindW'(fidx) : FindW'(s1_i.size));

    ins_mask = WinW'(s1_i.fmask) << s1_i.pos;
    ins_data = WinW'(s1_i.opnd) << s1_i.pos;
    bit_mask = WinW'(1) << s1_i.pos;

    s2_d.op    = s1_i.op;
    s2_d.fault = s1_i.fault;
    s2_d.found = 1'b0;
    s2_d.value = '0;
    s2_d.opnd  = s1_i.opnd;
    s2_d.upd   = s1_i.win;
    s2_d.wr    = 1'b0;
    s2_d.taken = 1'b0;

    case (s1_i.op)
      OP_EXTZV, OP_EXTV, OP_CMPZV, OP_CMPV: begin
        s2_d.value = ext_val;
      end
      OP_FFS, OP_FFC: begin
        s2_d.value = DataW'(fsum);
        s2_d.found = found;
      end
      OP_INSV: begin
        s2_d.upd = (s1_i.win & ~ins_mask) | (ins_data & ins_mask);
        s2_d.wr  = 1'b1;
      end
      OP_BBS: begin
        s2_d.value = DataW'(s1_i.tbit);
        s2_d.taken = s1_i.tbit;
      end
      OP_BBC: begin
        s2_d.value = DataW'(s1_i.tbit);
        s2_d.taken = !s1_i.tbit;
      end
      OP_BBSS: begin
        s2_d.value = DataW'(s1_i.tbit);
        s2_d.taken = s1_i.tbit;
        s2_d.upd   = s1_i.win | bit_mask;
        s2_d.wr    = 1'b1;
      end
      OP_BBCS: begin
        s2_d.value = DataW'(s1_i.tbit);
        s2_d.taken = !s1_i.tbit;
        s2_d.upd   = s1_i.win | bit_mask;
        s2_d.wr    = 1'b1;
      end
      OP_BBSC: begin
        s2_d.value = DataW'(s1_i.tbit);
        s2_d.taken = s1_i.tbit;
        s2_d.upd   = s1_i.win & ~bit_mask;
        s2_d.wr    = 1'b1;
      end
      OP_BBCC: begin
        s2_d.value = DataW'(s1_i.tbit);
        s2_d.taken = !s1_i.tbit;
        s2_d.upd   = s1_i.win & ~bit_mask;
        s2_d.wr    = 1'b1;
      end
      default: begin
      end
    endcase

    // reserved operand leaves the window alone and zeroes the rest
    if (s1_i.fault) begin
      s2_d.value = '0;
      s2_d.found = 1'b0;
      s2_d.upd   = s1_i.win;
      s2_d.wr    = 1'b0;
      s2_d.taken = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s2_q <= s2_d;
    end
  end

endmodule

// ===== rtl/bfe_flags.sv =====
// stage 3: condition codes and the result register
`timescale 1ns / 1ps
`include "bit_field_execute_unit_top_macros.svh"
module bfe_flags (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  bfe_pkg::s2_t s2_i,
  bfe_out_if.source    out_o
);
  import bfe_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [WinW-1:0]  upd;
    logic             wr;
    logic             n;
    logic             z;
    logic             c;
    logic             taken;
    logic             fault;
  } res_t;

  logic valid_q;
  res_t res_q;
  res_t res_d;
  logic is_ext;

  assign ready_o = !valid_q || out_o.ready;
  assign is_ext  = (s2_i.op == OP_EXTZV) || (s2_i.op == OP_EXTV);

  always_comb begin
    res_d.value = s2_i.value;
    res_d.upd   = s2_i.upd;
    res_d.wr    = s2_i.wr;
    res_d.taken = s2_i.taken;
    res_d.fault = s2_i.fault;
    res_d.n     = 1'b0;
    res_d.z     = 1'b0;
    res_d.c     = 1'b0;
    case (s2_i.op)
      OP_EXTZV, OP_EXTV: begin
        res_d.n = s2_i.value[DataW-1];
        res_d.z = (s2_i.value == '0);
      end
      OP_CMPZV, OP_CMPV: begin
        res_d.n = $signed(s2_i.value) < $signed(s2_i.opnd);
        res_d.z = (s2_i.value == s2_i.opnd);
        res_d.c = (s2_i.value < s2_i.opnd);
      end
      OP_FFS, OP_FFC: begin
        res_d.z = !s2_i.found;
      end
      default: begin
      end
    endcase
    if (s2_i.fault) begin
      res_d.n = 1'b0;
      res_d.z = 1'b0;
      res_d.c = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.value_out      = res_q.value;
  assign out_o.updated_window = res_q.upd;
  assign out_o.window_written = res_q.wr;
  assign out_o.flag_n         = res_q.n;
  assign out_o.flag_z         = res_q.z;
  assign out_o.flag_c         = res_q.c;
  assign out_o.flag_v         = 1'b0;
  assign out_o.branch_taken   = res_q.taken;
  assign out_o.reserved_fault = res_q.fault;

  `BFE_ASSERT_NOW(a_fault_quiet, out_o.valid && out_o.reserved_fault, !out_o.window_written && (out_o.value_out == '0) && !out_o.branch_taken, "faulted beat carries a result")
  `BFE_ASSERT_NEXT(a_ext_no_carry, valid_i && ready_o && is_ext, !out_o.flag_c, "extract beat set carry")
  `BFE_ASSERT_NOW(a_eq_not_less, out_o.valid && out_o.flag_c, !out_o.flag_z, "equal and less both set")

endmodule

// ===== tb/bit_field_execute_unit_top_tb.sv =====
// testbench of the bit-field execute unit: directed and random beats, self-checking
`timescale 1ns / 1ps
module bit_field_execute_unit_top_tb;
  import bfe_pkg::*;

  // op codes the unit leaves unused
  localparam logic [OpW-1:0] OpSpare13 = 4'd13;
  localparam logic [OpW-1:0] OpSpare14 = 4'd14;
  localparam logic [OpW-1:0] OpSpare15 = 4'd15;

  localparam logic [WinW-1:0]  AllOnesWin  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] AllOnesData = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] MaxPosData  = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [PosW-1:0]  pos;
    logic [SizeW-1:0] size;
    logic [WinW-1:0]  win;
    logic [DataW-1:0] opnd;
  } bf_item_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [WinW-1:0]  upd;
    logic             wr;
    logic             n;
    logic             z;
    logic             c;
    logic             v;
    logic             taken;
    logic             fault;
  } bf_result_t;

  class bitfield_scoreboard;
    bf_result_t expected_q[$];
    int errors;
    int checked;
    int accepted;
    int faults;
    int writes;
    int branches;

    function new();
      errors   = 0;
      checked  = 0;
      accepted = 0;
      faults   = 0;
      writes   = 0;
      branches = 0;
    endfunction

    function bf_result_t predict(bf_item_t it);
      bf_result_t   r;
      logic [63:0]  fmask;
      logic [63:0]  m;
      logic [31:0]  field;
      logic         want;
      r     = '0;
      r.upd = it.win;
      if (it.op <= OP_INSV && it.size > MaxField) begin
        r.fault = 1'b1;
      end else if (it.op <= OP_INSV) begin
        fmask = (64'd1 << it.size) - 64'd1;
        field = 32'((it.win >> it.pos) & fmask);
        case (it.op)
          OP_EXTZV, OP_EXTV, OP_CMPZV, OP_CMPV: begin
            r.value = field;
            if ((it.op == OP_EXTV || it.op == OP_CMPV) && it.size != 0 &&
                field[it.size - 1]) begin
              r.value = field | ~32'(fmask);
            end
            if (it.op == OP_EXTZV || it.op == OP_EXTV) begin
              r.n = r.value[31];
              r.z = (r.value == 0);
            end else begin
              r.n = ($signed(r.value) < $signed(it.opnd));
              r.z = (r.value == it.opnd);
              r.c = (r.value < it.opnd);
            end
          end
          OP_FFS, OP_FFC: begin
            // not found leaves position + size
            r.value = 32'(it.pos) + 32'(it.size);
            r.z     = 1'b1;
            for (int i = 0; i < it.size; i++) begin
              if (field[i] == (it.op == OP_FFS)) begin
                r.value = 32'(it.pos) + 32'(i);
                r.z     = 1'b0;
                break;
              end
            end
          end
          default: begin
            m     = fmask << it.pos;
            r.upd = (it.win & ~m) | ((64'(it.opnd) << it.pos) & m);
            r.wr  = 1'b1;
          end
        endcase
      end else if (it.op <= OP_BBCC) begin
        r.value = 32'(it.win[it.pos]);
        want    = !(it.op == OP_BBC || it.op == OP_BBCS || it.op == OP_BBCC);
        r.taken = (it.win[it.pos] == want);
        if (it.op >= OP_BBSS) begin
          r.wr = 1'b1;
          r.upd[it.pos] = (it.op == OP_BBSS || it.op == OP_BBCS);
        end
      end
      return r;
    endfunction

    function void note_input(bf_item_t it);
      accepted++;
      expected_q.push_back(predict(it));
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(bf_result_t got);
      bf_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none, actual value %0h",
                 $time, got.value);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      faults   += want.fault;
      writes   += want.wr;
      branches += want.taken;
      compare_field("value_out", 64'(want.value), 64'(got.value));
      compare_field("updated_window", want.upd, got.upd);
      compare_field("window_written", 64'(want.wr), 64'(got.wr));
      compare_field("flag_n", 64'(want.n), 64'(got.n));
      compare_field("flag_z", 64'(want.z), 64'(got.z));
      compare_field("flag_c", 64'(want.c), 64'(got.c));
      compare_field("flag_v", 64'(want.v), 64'(got.v));
      compare_field("branch_taken", 64'(want.taken), 64'(got.taken));
      compare_field("reserved_fault", 64'(want.fault), 64'(got.fault));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bfe_in_if  in_if ();
  bfe_out_if out_if ();

  bit_field_execute_unit_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  bitfield_scoreboard sb;
  int rx_stall_pct = 0;
  int hold_request = 0;

  // monitors sample the pre-edge values of both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_input('{op: in_if.op, pos: in_if.position, size: in_if.field_size,
                        win: in_if.source_window, opnd: in_if.operand});
      if (out_if.valid && out_if.ready)
        sb.check_result('{value: out_if.value_out, upd: out_if.updated_window,
                          wr: out_if.window_written, n: out_if.flag_n,
                          z: out_if.flag_z, c: out_if.flag_c, v: out_if.flag_v,
                          taken: out_if.branch_taken, fault: out_if.reserved_fault});
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_beat(input bf_item_t it, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= it.op;
    in_if.position      <= it.pos;
    in_if.field_size    <= it.size;
    in_if.source_window <= it.win;
    in_if.operand       <= it.opnd;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_directed(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                               input logic [SizeW-1:0] size, input logic [WinW-1:0] win,
                               input logic [DataW-1:0] opnd);
    send_beat('{op: op, pos: pos, size: size, win: win, opnd: opnd}, 0);
  endtask

  function automatic bf_item_t random_item();
    bf_item_t   it;
    bf_result_t r;
    int         pick;
    if ($urandom_range(99) < 5) it.op = OpW'($urandom_range(13, 15));
    else                        it.op = OpW'($urandom_range(0, 12));
    it.pos = PosW'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 78)      it.size = SizeW'($urandom_range(0, 32));
    else if (pick < 86) it.size = ($urandom_range(1)) ? 8'd32 : 8'd0;
    else                it.size = SizeW'($urandom_range(33, 255));
    // sparse and dense windows give finds something to look for
    case ($urandom_range(3))
      0: it.win = {$urandom, $urandom};
      1: it.win = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: it.win = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      default: begin
        case ($urandom_range(2))
          0: it.win = '0;
          1: it.win = AllOnesWin;
          default: it.win = 64'd1 << $urandom_range(63);
        endcase
      end
    endcase
    pick = $urandom_range(99);
    if (pick < 10)      it.opnd = '0;
    else if (pick < 20) it.opnd = AllOnesData;
    else                it.opnd = $urandom;
    // hit the equal case of compares now and then
    if ((it.op == OP_CMPZV || it.op == OP_CMPV) && $urandom_range(99) < 30) begin
      r = sb.predict(it);
      it.opnd = r.value;
    end
    return it;
  endfunction

  task automatic run_phase(input int count, input int tx_idle_pct, input int rx_pct);
    rx_stall_pct = rx_pct;
    repeat (count) send_beat(random_item(), tx_idle_pct);
  endtask

  initial begin
    sb = new();
    in_if.valid         <= 1'b0;
    in_if.op            <= '0;
    in_if.position      <= '0;
    in_if.field_size    <= '0;
    in_if.source_window <= '0;
    in_if.operand       <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extracts at the extremes, sign and zero size
    send_directed(OP_EXTZV, 5'd0, 8'd32, AllOnesWin, '0);
    send_directed(OP_EXTZV, 5'd31, 8'd32, 64'h8000_0001_2345_6789, '0);
    send_directed(OP_EXTV, 5'd4, 8'd8, 64'h0000_0000_0000_0F80, '0);
    send_directed(OP_EXTV, 5'd9, 8'd0, AllOnesWin, AllOnesData);
    send_directed(OP_EXTV, 5'd31, 8'd32, 64'hFFFF_FFFF_0000_0000, '0);
    // compares: equal, signed vs unsigned, zero size
    send_directed(OP_CMPZV, 5'd8, 8'd16, 64'h0000_0000_00AB_CD00, 32'h0000_ABCD);
    send_directed(OP_CMPV, 5'd0, 8'd4, 64'h0000_0000_0000_0008, 32'd3);
    send_directed(OP_CMPZV, 5'd3, 8'd0, AllOnesWin, '0);
    send_directed(OP_CMPV, 5'd1, 8'd32, AllOnesWin, MaxPosData);
    // finds: found, not found, zero size
    send_directed(OP_FFS, 5'd2, 8'd20, 64'h0000_0000_0000_4000, '0);
    send_directed(OP_FFS, 5'd31, 8'd32, '0, '0);
    send_directed(OP_FFC, 5'd0, 8'd32, AllOnesWin, '0);
    send_directed(OP_FFC, 5'd16, 8'd16, 64'h0000_0000_FF7F_FFFF, '0);
    send_directed(OP_FFS, 5'd7, 8'd0, AllOnesWin, '0);
    // inserts, including zero size and a reserved size
    send_directed(OP_INSV, 5'd31, 8'd32, '0, AllOnesData);
    send_directed(OP_INSV, 5'd5, 8'd0, 64'h1234_5678_9ABC_DEF0, AllOnesData);
    send_directed(OP_INSV, 5'd0, 8'd33, 64'h1234_5678_9ABC_DEF0, AllOnesData);
    send_directed(OP_EXTZV, 5'd0, 8'd255, AllOnesWin, '0);
    send_directed(OP_FFS, 5'd12, 8'd33, AllOnesWin, '0);
    // branch-on-bit ignores the field size
    send_directed(OP_BBS, 5'd31, 8'd255, 64'h0000_0000_8000_0000, '0);
    send_directed(OP_BBC, 5'd0, 8'd255, AllOnesWin, '0);
    send_directed(OP_BBSS, 5'd31, 8'd1, '0, '0);
    send_directed(OP_BBCS, 5'd0, 8'd1, '0, '0);
    send_directed(OP_BBSC, 5'd17, 8'd1, AllOnesWin, '0);
    send_directed(OP_BBCC, 5'd17, 8'd1, AllOnesWin, '0);
    send_directed(OpSpare13, 5'd3, 8'd255, AllOnesWin, AllOnesData);
    send_directed(OpSpare14, 5'd31, 8'd4, 64'h0123_4567_89AB_CDEF, 32'h5A5A_5A5A);
    send_directed(OpSpare15, 5'd0, 8'd0, '0, '0);

    run_phase(375, 0, 0);
    run_phase(375, 63, 0);
    run_phase(375, 0, 63);
    run_phase(375, 32, 32);
    // long result hold-off so the pipe fills and backs up the input
    hold_request = 300;
    run_phase(400, 0, 0);
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d input beats and %0d result beats over all ops and idle mixes",
             sb.accepted, sb.checked);
    $display("saw %0d reserved faults, %0d window writes, %0d taken branches",
             sb.faults, sb.writes, sb.branches);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("FAIL");
    $finish;
  end

endmodule
